// ===== rtl/core/positional_ordered_list_assert.svh =====
// Assertion macros used by the checker file of the ordered list.
`ifndef POSITIONAL_ORDERED_LIST_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define POL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional_ordered_list: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define POL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional_ordered_list: next-cycle check failed");

`endif

// ===== rtl/core/pol_pkg.sv =====
// Types and constants shared by the ordered list modules.
package pol_pkg;

  // Fixed field widths of the request and result items.
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 7;
  localparam int FOUND_W     = 6;
  localparam int COUNT_OUT_W = 7;

  // Request actions.
  typedef enum logic [2:0] {
    ACT_APPEND       = 3'd0,
    ACT_PREPEND      = 3'd1,
    ACT_INSERT       = 3'd2,
    ACT_REMOVE_FIRST = 3'd3,
    ACT_REMOVE_LAST  = 3'd4,
    ACT_REMOVE_AT    = 3'd5,
    ACT_SEARCH       = 3'd6,
    ACT_CLEAR        = 3'd7
  } action_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // One request item.
  typedef struct packed {
    action_t                    action;
    logic signed [VALUE_W-1:0]  value;
    logic        [POS_W-1:0]    position;
  } request_t;

  // One result item.
  typedef struct packed {
    status_t                    status;
    logic [FOUND_W-1:0]         found_index;
    logic [COUNT_OUT_W-1:0]     entry_count;
  } result_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_PUT,
    S_SEARCH,
    S_REPORT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic move;
    logic search;
    logic put;
    logic finish;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic plan_move;
    logic plan_search;
    logic op_ins;
    logic move_done;
    logic search_done;
  } dp_stat_t;

endpackage

// ===== rtl/core/positional_ordered_list.sv =====
// Top level of the fixed-capacity positional ordered list.
//
//   Channel   Handshake          Payload
//   request   start, busy        request (action, value, position)
//   result    done (one cycle)   result (status, found_index, entry_count)
//
// An item is taken when start is high while busy is low; its result shows on result
// for the single cycle that done is high, the first cycle in which busy is low again.
// Busy stays high while the item runs: an insert shifts the entries from its index k
// toward the tail, then writes the new value, a remove shifts the entries behind k toward
// the head, a search compares from the head to a hit or the end, and a clear or rejected
// item reports directly; the single read and write port moves one entry a cycle.
// Reset empties the list at once; the entry memory itself is not cleared.
// The receiver cannot stall: a new item may be taken in the cycle done is high.
module positional_ordered_list #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pol_pkg::request_t request,
  output logic              done,
  output pol_pkg::result_t  result
);

  pol_pkg::ctl_cmd_t cmd;
  pol_pkg::dp_stat_t stat;

  pol_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  pol_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

// ===== rtl/core/pol_dpath.sv =====
// Datapath of the ordered list: entry memory, count, walk pointer and result.
module pol_dpath #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  pol_pkg::request_t  request,
  input  pol_pkg::ctl_cmd_t  cmd,
  output pol_pkg::dp_stat_t  stat,
  output logic               done,
  output pol_pkg::result_t   result
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int POS_W = pol_pkg::POS_W;
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int FW = pol_pkg::FOUND_W;
  localparam int NW = pol_pkg::COUNT_OUT_W;
  localparam int VW = pol_pkg::VALUE_W;

  // Entry memory, one write and one registered read per cycle.
  logic [VW-1:0] mem [CAPACITY];
  logic [VW-1:0] rd_data;

  // Control registers.
  logic [CW-1:0] count;
  logic          pend;
  logic          cmp_v;
  logic          hit;
  logic          op_ins;
  logic          op_rem;
  logic          op_srch;
  logic          op_clr;
  logic          reject_full;
  logic          reject_empty;

  // Payload registers.
  logic [VW-1:0] req_value;
  logic [IW-1:0] at;
  logic [IW-1:0] walk;
  logic [CW-1:0] left;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] cmp_idx;
  logic [IW-1:0] found;

  // Request decode, used in the cycle the item is taken.
  logic          is_ins;
  logic          is_rem;
  logic          full;
  logic          empty;
  logic          past_end;
  logic [XW-1:0] count_x;
  logic [XW-1:0] pos_x;
  logic [CW-1:0] ins_at;
  logic [CW-1:0] rem_at;

  // Memory port control and end-of-item values.
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [VW-1:0] mem_wd;
  logic [IW-1:0] move_dst;
  logic [CW-1:0] count_next;
  pol_pkg::status_t status_next;
  logic [IW+FW-1:0] found_ext;
  logic [CW+NW-1:0] count_ext;

  // Classify the incoming request and clamp its position.
  always_comb begin
    is_ins   = (request.action == pol_pkg::ACT_APPEND) ||
               (request.action == pol_pkg::ACT_PREPEND) ||
               (request.action == pol_pkg::ACT_INSERT);
    is_rem   = (request.action == pol_pkg::ACT_REMOVE_FIRST) ||
               (request.action == pol_pkg::ACT_REMOVE_LAST) ||
               (request.action == pol_pkg::ACT_REMOVE_AT);
    full     = (count == CW'(CAPACITY));
    empty    = (count == '0);
    count_x  = XW'(count);
    pos_x    = XW'(request.position);
    past_end = (pos_x >= count_x);
    case (request.action)
      pol_pkg::ACT_APPEND:  ins_at = count;
      pol_pkg::ACT_PREPEND: ins_at = '0;
      default:              ins_at = past_end ? count : CW'(pos_x);
    endcase
    case (request.action)
      pol_pkg::ACT_REMOVE_FIRST: rem_at = '0;
      pol_pkg::ACT_REMOVE_LAST:  rem_at = count - CW'(1);
      default:                   rem_at = past_end ? (count - CW'(1)) : CW'(pos_x);
    endcase
  end

  // Plan and progress reported to the controller.
  always_comb begin
    stat.plan_move   = (is_ins && !full) || (is_rem && !empty);
    stat.plan_search = (request.action == pol_pkg::ACT_SEARCH);
    stat.op_ins      = op_ins;
    stat.move_done   = (left == '0) && !pend;
    stat.search_done = hit || ((left == '0) && !cmp_v);
  end

  // A shift copies toward the tail on insert and toward the head on remove.
  assign move_dst = op_ins ? (walk + IW'(1)) : (walk - IW'(1));

  // A pending shift write wins; the new value goes in once the shift drains.
  always_comb begin
    mem_we = pend || cmd.put;
    mem_wa = pend ? wr_addr : at;
    mem_wd = pend ? rd_data : req_value;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[walk];
  end

  // Count and status at the end of the item.
  always_comb begin
    if (op_clr) begin
      count_next = '0;
    end else if (op_ins) begin
      count_next = count + CW'(1);
    end else if (op_rem) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
    if (reject_full) begin
      status_next = pol_pkg::ST_FULL;
    end else if (reject_empty) begin
      status_next = pol_pkg::ST_EMPTY;
    end else if (op_srch && !hit) begin
      status_next = pol_pkg::ST_MISS;
    end else begin
      status_next = pol_pkg::ST_DONE;
    end
    found_ext = (op_srch && hit) ? (IW + FW)'(found) : '0;
    count_ext = (CW + NW)'(count_next);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      pend         <= 1'b0;
      cmp_v        <= 1'b0;
      hit          <= 1'b0;
      done         <= 1'b0;
      op_ins       <= 1'b0;
      op_rem       <= 1'b0;
      op_srch      <= 1'b0;
      op_clr       <= 1'b0;
      reject_full  <= 1'b0;
      reject_empty <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.load) begin
        pend         <= 1'b0;
        cmp_v        <= 1'b0;
        hit          <= 1'b0;
        op_ins       <= is_ins && !full;
        op_rem       <= is_rem && !empty;
        op_srch      <= (request.action == pol_pkg::ACT_SEARCH);
        op_clr       <= (request.action == pol_pkg::ACT_CLEAR);
        reject_full  <= is_ins && full;
        reject_empty <= is_rem && empty;
      end
      if (cmd.move) begin
        pend <= (left != '0);
      end
      if (cmd.search) begin
        cmp_v <= (left != '0) && !hit;
        if (cmp_v && !hit && (rd_data == req_value)) begin
          hit <= 1'b1;
        end
      end
      if (cmd.finish) begin
        count <= count_next;
      end
    end
  end

  // Payload registers: walk pointer, shift target, compare tag and result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_value <= request.value;
      if (is_ins) begin
        at   <= IW'(ins_at);
        walk <= IW'(count - CW'(1));
        left <= count - ins_at;
      end else if (is_rem) begin
        at   <= IW'(rem_at);
        walk <= IW'(rem_at + CW'(1));
        left <= count - CW'(1) - rem_at;
      end else begin
        at   <= '0;
        walk <= '0;
        left <= count;
      end
    end
    if (cmd.move && (left != '0)) begin
      wr_addr <= move_dst;
      walk    <= op_ins ? (walk - IW'(1)) : (walk + IW'(1));
      left    <= left - CW'(1);
    end
    if (cmd.search) begin
      if ((left != '0) && !hit) begin
        cmp_idx <= walk;
        walk    <= walk + IW'(1);
        left    <= left - CW'(1);
      end
      if (cmp_v && !hit && (rd_data == req_value)) begin
        found <= cmp_idx;
      end
    end
    if (cmd.finish) begin
      result.status      <= status_next;
      result.found_index <= found_ext[FW-1:0];
      result.entry_count <= count_ext[NW-1:0];
    end
  end

endmodule

// ===== rtl/core/pol_ctrl.sv =====
// Controller state machine that sequences each ordered list item.
module pol_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pol_pkg::dp_stat_t  stat,
  output pol_pkg::ctl_cmd_t  cmd,
  output logic               busy
);

  pol_pkg::state_t state;
  pol_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pol_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pol_pkg::S_IDLE: begin
        if (start) begin
          if (stat.plan_move) begin
            state_next = pol_pkg::S_MOVE;
          end else if (stat.plan_search) begin
            state_next = pol_pkg::S_SEARCH;
          end else begin
            state_next = pol_pkg::S_REPORT;
          end
        end
      end
      pol_pkg::S_MOVE: begin
        if (stat.move_done) begin
          state_next = stat.op_ins ? pol_pkg::S_PUT : pol_pkg::S_REPORT;
        end
      end
      pol_pkg::S_PUT: begin
        state_next = pol_pkg::S_REPORT;
      end
      pol_pkg::S_SEARCH: begin
        if (stat.search_done) begin
          state_next = pol_pkg::S_REPORT;
        end
      end
      pol_pkg::S_REPORT: begin
        state_next = pol_pkg::S_IDLE;
      end
      default: begin
        state_next = pol_pkg::S_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      pol_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      pol_pkg::S_MOVE: begin
        cmd.move = 1'b1;
      end
      pol_pkg::S_PUT: begin
        cmd.put = 1'b1;
      end
      pol_pkg::S_SEARCH: begin
        cmd.search = 1'b1;
      end
      pol_pkg::S_REPORT: begin
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/core/pol_checker.sv =====
// Port-level checks on the ordered list, bound to its top level.
`include "positional_ordered_list_assert.svh"

module pol_checker #(
  parameter int CAPACITY = 64
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input pol_pkg::result_t result
);

  localparam int NW = pol_pkg::COUNT_OUT_W;
  localparam logic [NW-1:0] CAP_OUT = NW'(CAPACITY);

  // An accepted item keeps the block busy in the following cycle.
  `POL_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // A result only follows a cycle in which an item was in progress.
  `POL_ASSERT_NOW(a_done_after_busy, clk, rst, done, $past(busy))

  // A nonzero found index only comes with a successful search.
  `POL_ASSERT_NOW(a_found_status, clk, rst, done && (result.found_index != '0),
                  result.status == pol_pkg::ST_DONE)

  // A rejected insert reports a full list.
  `POL_ASSERT_NOW(a_full_count, clk, rst, done && (result.status == pol_pkg::ST_FULL),
                  result.entry_count == CAP_OUT)

  // A remove from an empty list reports an empty list.
  `POL_ASSERT_NOW(a_empty_count, clk, rst, done && (result.status == pol_pkg::ST_EMPTY),
                  result.entry_count == '0)

endmodule

bind positional_ordered_list pol_checker #(.CAPACITY(CAPACITY)) u_pol_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the positional ordered list: directed and random items.
module tb;

  localparam int CAP           = 64;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int SETTLE_CYCLES = 80;
  localparam int CALM_FIRST    = 1000;
  localparam int CALM_LAST     = 1300;
  localparam int PW            = pol_pkg::POS_W;
  localparam int FW            = pol_pkg::FOUND_W;
  localparam int NW            = pol_pkg::COUNT_OUT_W;

  // Bias of the random stream: grow the list, shrink it, or keep it level.
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  typedef struct {
    pol_pkg::request_t req;
    bit                drain;
  } pending_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  pol_pkg::request_t request = '0;
  logic              done;
  pol_pkg::result_t  result;

  positional_ordered_list #(.CAPACITY(CAP)) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  pending_t           pending[$];
  pol_pkg::result_t   expected[$];
  logic signed [31:0] shadow[CAP];
  int                 shadow_count = 0;
  bit                 took = 1'b0;
  int                 items_sent = 0;
  int                 error_count = 0;
  int                 action_seen[8];
  int                 status_seen[4];
  logic signed [31:0] value_pool[8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the shadow list and returns the result it should give.
  function automatic pol_pkg::result_t apply_request(pol_pkg::request_t rq);
    pol_pkg::result_t rs;
    int               at;
    int               i;
    rs = '0;
    rs.status = pol_pkg::ST_DONE;
    case (rq.action)
      pol_pkg::ACT_APPEND, pol_pkg::ACT_PREPEND, pol_pkg::ACT_INSERT: begin
        if (shadow_count >= CAP) begin
          rs.status = pol_pkg::ST_FULL;
        end else begin
          if (rq.action == pol_pkg::ACT_APPEND) at = shadow_count;
          else if (rq.action == pol_pkg::ACT_PREPEND) at = 0;
          else at = (int'(rq.position) > shadow_count) ? shadow_count : int'(rq.position);
          for (i = shadow_count; i > at; i--) shadow[i] = shadow[i-1];
          shadow[at] = rq.value;
          shadow_count++;
        end
      end
      pol_pkg::ACT_REMOVE_FIRST, pol_pkg::ACT_REMOVE_LAST, pol_pkg::ACT_REMOVE_AT: begin
        if (shadow_count == 0) begin
          rs.status = pol_pkg::ST_EMPTY;
        end else begin
          if (rq.action == pol_pkg::ACT_REMOVE_FIRST) at = 0;
          else if (rq.action == pol_pkg::ACT_REMOVE_LAST) at = shadow_count - 1;
          else at = (int'(rq.position) >= shadow_count) ? shadow_count - 1
                                                         : int'(rq.position);
          for (i = at; i + 1 < shadow_count; i++) shadow[i] = shadow[i+1];
          shadow_count--;
        end
      end
      pol_pkg::ACT_SEARCH: begin
        rs.status = pol_pkg::ST_MISS;
        for (i = 0; i < shadow_count && rs.status == pol_pkg::ST_MISS; i++) begin
          if (shadow[i] == rq.value) begin
            rs.status = pol_pkg::ST_DONE;
            rs.found_index = FW'(i);
          end
        end
      end
      pol_pkg::ACT_CLEAR: shadow_count = 0;
    endcase
    rs.entry_count = NW'(shadow_count);
    return rs;
  endfunction

  // Values mostly come from a small pool so that searches hit stored entries.
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 99) < 60) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Positions mostly stay within 0 to the capacity, the rest cover the whole field.
  function automatic logic [PW-1:0] pick_position();
    if ($urandom_range(0, 99) < 65) return PW'($urandom_range(0, CAP));
    return PW'($urandom_range(0, 127));
  endfunction

  function automatic pol_pkg::action_t pick_action(mix_t mix);
    int r;
    int ins_pct;
    int rem_pct;
    int clr_pct;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin ins_pct = 70; rem_pct = 15; clr_pct = 0; end
      MIX_DRAIN: begin ins_pct = 20; rem_pct = 60; clr_pct = 1; end
      default:   begin ins_pct = 40; rem_pct = 35; clr_pct = 2; end
    endcase
    if (r < ins_pct) begin
      return pol_pkg::action_t'($urandom_range(pol_pkg::ACT_APPEND, pol_pkg::ACT_INSERT));
    end
    if (r < ins_pct + rem_pct) begin
      return pol_pkg::action_t'($urandom_range(pol_pkg::ACT_REMOVE_FIRST,
                                               pol_pkg::ACT_REMOVE_AT));
    end
    if (r >= 100 - clr_pct) return pol_pkg::ACT_CLEAR;
    return pol_pkg::ACT_SEARCH;
  endfunction

  function automatic void queue_item(pol_pkg::action_t act, logic signed [31:0] val,
                                     logic [PW-1:0] pos, bit drain);
    pending_t p;
    p.req.action   = act;
    p.req.value    = val;
    p.req.position = pos;
    p.drain        = drain;
    pending.push_back(p);
  endfunction

  // Driver: presents the oldest pending item and holds it until it is taken.
  always @(negedge clk) begin
    bit launch;
    launch = 1'b0;
    if (!rst) begin
      if (took) begin
        took = 1'b0;
        pending.delete(0);
        items_sent++;
      end else if (start) begin
        launch = 1'b1;
      end
      if (!launch && pending.size() != 0 && !(pending[0].drain && expected.size() != 0)) begin
        launch = (items_sent >= CALM_FIRST && items_sent < CALM_LAST) ||
                 $urandom_range(0, 99) >= 32;
      end
    end
    start <= launch;
    if (launch) request <= pending[0].req;
  end

  // Monitor: checks each result against the oldest prediction, then predicts new items.
  always @(posedge clk) begin
    pol_pkg::result_t want;
    if (!rst) begin
      if (done) begin
        if (expected.size() == 0) begin
          $error("unexpected result: status %0d found_index %0d entry_count %0d",
                 result.status, result.found_index, result.entry_count);
          error_count++;
        end else begin
          want = expected.pop_front();
          status_seen[want.status]++;
          if (result.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, result.status);
            error_count++;
          end
          if (result.found_index !== want.found_index) begin
            $error("found_index: expected %0d, actual %0d", want.found_index,
                   result.found_index);
            error_count++;
          end
          if (result.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   result.entry_count);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        took = 1'b1;
        action_seen[request.action]++;
        expected.push_back(apply_request(request));
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    mix_t mix;
    int   n;
    value_pool[0] = 32'sd0;
    value_pool[1] = -32'sd1;
    value_pool[2] = 32'sd1;
    value_pool[3] = 32'sh8000_0000;
    value_pool[4] = 32'sh7fff_ffff;
    value_pool[5] = 32'sh5a5a_5a5a;
    value_pool[6] = 32'sha5a5_a5a5;
    value_pool[7] = 32'sd7;

    // Directed part: empty-list cases, edge values and edge positions.
    queue_item(pol_pkg::ACT_SEARCH,       32'sd0,          7'd0,   1'b0);
    queue_item(pol_pkg::ACT_REMOVE_FIRST, 32'sd0,          7'd0,   1'b0);
    queue_item(pol_pkg::ACT_REMOVE_LAST,  32'sd0,          7'd0,   1'b0);
    queue_item(pol_pkg::ACT_REMOVE_AT,    32'sd0,          7'd0,   1'b0);
    queue_item(pol_pkg::ACT_CLEAR,        32'sd0,          7'd0,   1'b0);
    queue_item(pol_pkg::ACT_APPEND,       32'sh7fff_ffff,  7'd0,   1'b0);
    queue_item(pol_pkg::ACT_PREPEND,      32'sh8000_0000,  7'd0,   1'b0);
    queue_item(pol_pkg::ACT_INSERT,       -32'sd1,         7'd0,   1'b0);
    queue_item(pol_pkg::ACT_INSERT,       32'sd0,          7'd127, 1'b0);
    queue_item(pol_pkg::ACT_INSERT,       32'sd1,          7'd4,   1'b0);
    queue_item(pol_pkg::ACT_INSERT,       32'sh5a5a_5a5a,  7'd2,   1'b0);
    queue_item(pol_pkg::ACT_SEARCH,       32'sh8000_0000,  7'd0,   1'b0);
    queue_item(pol_pkg::ACT_SEARCH,       32'sd1,          7'd0,   1'b0);
    queue_item(pol_pkg::ACT_SEARCH,       32'sd12345,      7'd0,   1'b0);
    queue_item(pol_pkg::ACT_SEARCH,       -32'sd1,         7'd0,   1'b0);
    queue_item(pol_pkg::ACT_REMOVE_AT,    32'sd0,          7'd127, 1'b0);
    queue_item(pol_pkg::ACT_REMOVE_AT,    32'sd0,          7'd1,   1'b0);
    queue_item(pol_pkg::ACT_REMOVE_AT,    32'sd0,          7'd3,   1'b0);
    queue_item(pol_pkg::ACT_REMOVE_FIRST, 32'sd0,          7'd0,   1'b0);
    queue_item(pol_pkg::ACT_REMOVE_LAST,  32'sd0,          7'd0,   1'b0);
    queue_item(pol_pkg::ACT_APPEND,       32'sd7,          7'd0,   1'b0);
    queue_item(pol_pkg::ACT_CLEAR,        32'sd0,          7'd0,   1'b0);
    queue_item(pol_pkg::ACT_SEARCH,       32'sd7,          7'd0,   1'b0);

    // Random part: biased to fill first, to drain next, then blocks of a random bias.
    mix = MIX_FILL;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) mix = MIX_DRAIN;
      else if (n >= 300 && n % 150 == 0) mix = mix_t'($urandom_range(MIX_FILL, MIX_EVEN));
      queue_item(pick_action(mix), pick_value(), pick_position(), n % 500 == 0);
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending.size() != 0 || start) @(posedge clk);
    while (expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d items: %0d inserts, %0d removes, %0d searches, %0d clears.",
             items_sent, action_seen[pol_pkg::ACT_APPEND] +
             action_seen[pol_pkg::ACT_PREPEND] + action_seen[pol_pkg::ACT_INSERT],
             action_seen[pol_pkg::ACT_REMOVE_FIRST] + action_seen[pol_pkg::ACT_REMOVE_LAST] +
             action_seen[pol_pkg::ACT_REMOVE_AT],
             action_seen[pol_pkg::ACT_SEARCH], action_seen[pol_pkg::ACT_CLEAR]);
    $display("Saw %0d inserts rejected on a full list, %0d removes on an empty list,",
             status_seen[pol_pkg::ST_FULL], status_seen[pol_pkg::ST_EMPTY]);
    $display("and %0d search misses.", status_seen[pol_pkg::ST_MISS]);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pol_pkg.sv
rtl/core/pol_dpath.sv
rtl/core/pol_ctrl.sv
rtl/core/positional_ordered_list.sv
rtl/core/pol_checker.sv
sim/tb.sv
